// File: hw/rtl/wto_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wto_pkg
// Shared types and constants of the wavetable oscillator.
// ----------------------------------------------------------------------------
package wto_pkg;

  localparam int TABLE_SIZE  = 4096;
  localparam int TABLE_COUNT = 128;
  localparam int MAP_DEPTH   = 32768;
  localparam int SAMPLE_BITS = 16;

  localparam int FRAC_BITS   = 20;
  localparam int POS_W       = $clog2(TABLE_SIZE);
  localparam int TNUM_W      = $clog2(TABLE_COUNT);
  localparam int KEY_W       = $clog2(MAP_DEPTH);
  localparam int TABLE_DEPTH = TABLE_SIZE * TABLE_COUNT;
  localparam int TADDR_W     = TNUM_W + POS_W;
  localparam int PHASE_W     = POS_W + FRAC_BITS;
  localparam int INC_W       = 31;
  localparam int VOL_W       = 16;

  // interpolation and gain product widths
  localparam int DIFF_W  = SAMPLE_BITS + 1;
  localparam int PROD1_W = SAMPLE_BITS + FRAC_BITS + 1;
  localparam int PROD2_W = PROD1_W + VOL_W;
  localparam int RND_W   = PROD2_W + 1;
  localparam int SHIFT   = FRAC_BITS + VOL_W;
  localparam int RES_W   = RND_W - SHIFT;

  localparam logic signed [RES_W-1:0] SAT_HI = RES_W'((1 << (SAMPLE_BITS - 1)) - 1);
  localparam logic signed [RES_W-1:0] SAT_LO = -RES_W'(1 << (SAMPLE_BITS - 1));

  typedef enum logic [1:0] {
    MODE_TICK      = 2'd0,
    MODE_NOTE_ON   = 2'd1,
    MODE_LOAD_WORD = 2'd2,
    MODE_LOAD_MAP  = 2'd3
  } mode_e;

  typedef enum logic [2:0] {
    ST_IDLE = 3'd0,
    ST_MUL1 = 3'd1,
    ST_MUL2 = 3'd2,
    ST_FIN  = 3'd3,
    ST_MAP  = 3'd4
  } state_e;

  localparam logic [2:0] REG_VOLUME = 3'd0;

  typedef struct packed {
    logic tick_rd;   // read both table neighbors
    logic note_on;   // load increment, clear phase, read map
    logic ld_word;   // write table store
    logic ld_map;    // write frequency map
    logic mul1;      // slope times fraction
    logic mul2;      // sum times gain
    logic fin;       // round, saturate, load output word, step phase
    logic map_sel;   // take table number from map read
  } cmd_t;

  typedef struct packed {
    logic out_free;  // output register can take a word this cycle
  } status_t;

endpackage

// File: hw/rtl/wto_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wto_ctrl
// Sequencer of the oscillator: decodes input words, steps the datapath.
// ----------------------------------------------------------------------------
module wto_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [1:0]        mode_i,
  input  wto_pkg::status_t  status_i,
  output wto_pkg::cmd_t     cmd_o
);

  wto_pkg::state_e state_q, state_d;
  wto_pkg::mode_e  mode;
  logic            accept;

  assign mode   = wto_pkg::mode_e'(mode_i);
  assign accept = in_valid_i && (state_q == wto_pkg::ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= wto_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      wto_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          unique case (mode)
            wto_pkg::MODE_TICK:    state_d = wto_pkg::ST_MUL1;
            wto_pkg::MODE_NOTE_ON: state_d = wto_pkg::ST_MAP;
            wto_pkg::MODE_LOAD_WORD,
            wto_pkg::MODE_LOAD_MAP: state_d = wto_pkg::ST_IDLE;
          endcase
        end
      end
      wto_pkg::ST_MUL1: state_d = wto_pkg::ST_MUL2;
      wto_pkg::ST_MUL2: state_d = wto_pkg::ST_FIN;
      wto_pkg::ST_FIN: begin
        if (status_i.out_free) begin
          state_d = wto_pkg::ST_IDLE;
        end
      end
      wto_pkg::ST_MAP:  state_d = wto_pkg::ST_IDLE;
      default:          state_d = wto_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o         = '0;
    in_ready_o    = (state_q == wto_pkg::ST_IDLE);
    cmd_o.tick_rd = accept && (mode == wto_pkg::MODE_TICK);
    cmd_o.note_on = accept && (mode == wto_pkg::MODE_NOTE_ON);
    cmd_o.ld_word = accept && (mode == wto_pkg::MODE_LOAD_WORD);
    cmd_o.ld_map  = accept && (mode == wto_pkg::MODE_LOAD_MAP);
    cmd_o.mul1    = (state_q == wto_pkg::ST_MUL1);
    cmd_o.mul2    = (state_q == wto_pkg::ST_MUL2);
    cmd_o.fin     = (state_q == wto_pkg::ST_FIN) && status_i.out_free;
    cmd_o.map_sel = (state_q == wto_pkg::ST_MAP);
  end

endmodule

// File: hw/rtl/wto_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wto_datapath
// Table and map memories, phase accumulator, interpolation, gain, output word.
// ----------------------------------------------------------------------------
module wto_datapath (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  wto_pkg::cmd_t                        cmd_i,
  output wto_pkg::status_t                     status_o,
  input  logic [wto_pkg::TNUM_W-1:0]           table_number_i,
  input  logic [wto_pkg::POS_W-1:0]            table_offset_i,
  input  logic signed [wto_pkg::SAMPLE_BITS-1:0] sample_value_i,
  input  logic [wto_pkg::KEY_W-1:0]            frequency_key_i,
  input  logic [wto_pkg::INC_W-1:0]            phase_increment_i,
  input  logic [wto_pkg::VOL_W-1:0]            volume_i,
  input  logic                                 out_ready_i,
  output logic                                 out_valid_o,
  output logic signed [wto_pkg::SAMPLE_BITS-1:0] sample_out_o,
  output logic                                 wrapped_o
);

  // every 7-bit table number and 12-bit offset addresses a real entry
  logic signed [wto_pkg::SAMPLE_BITS-1:0] table_mem [wto_pkg::TABLE_DEPTH];
  logic        [wto_pkg::TNUM_W-1:0]      map_mem   [wto_pkg::MAP_DEPTH];

  logic [wto_pkg::PHASE_W-1:0] phase_q;
  logic [wto_pkg::INC_W-1:0]   increment_q;
  logic [wto_pkg::TNUM_W-1:0]  cur_table_q;
  logic [wto_pkg::TNUM_W-1:0]  map_q;

  logic signed [wto_pkg::SAMPLE_BITS-1:0] a_q, b_q;
  logic signed [wto_pkg::PROD1_W-1:0]     prod1_q;
  logic signed [wto_pkg::PROD2_W-1:0]     prod2_q;

  logic                                   out_valid_q;
  logic signed [wto_pkg::SAMPLE_BITS-1:0] sample_q;
  logic                                   wrapped_q;

  logic [wto_pkg::POS_W-1:0]    pos, nxt;
  logic [wto_pkg::TADDR_W-1:0]  addr_a, addr_b, addr_w;
  logic signed [wto_pkg::DIFF_W-1:0]      diff;
  logic signed [wto_pkg::FRAC_BITS:0]     frac;
  logic signed [wto_pkg::PROD1_W-1:0]     s_sum;
  logic signed [wto_pkg::VOL_W:0]         gain;
  logic signed [wto_pkg::RND_W-1:0]       rnd;
  logic signed [wto_pkg::RES_W-1:0]       res;
  logic signed [wto_pkg::SAMPLE_BITS-1:0] sat;
  logic [wto_pkg::PHASE_W:0]              sum;

  assign pos    = phase_q[wto_pkg::PHASE_W-1:wto_pkg::FRAC_BITS];
  assign nxt    = pos + wto_pkg::POS_W'(1);
  assign addr_a = {cur_table_q, pos};
  assign addr_b = {cur_table_q, nxt};
  assign addr_w = {table_number_i, table_offset_i};

  // s = a*2^20 + (b - a)*m, same as a*(2^20 - m) + b*m
  assign diff  = wto_pkg::DIFF_W'(b_q) - wto_pkg::DIFF_W'(a_q);
  assign frac  = $signed({1'b0, phase_q[wto_pkg::FRAC_BITS-1:0]});
  assign s_sum = (wto_pkg::PROD1_W'(a_q) <<< wto_pkg::FRAC_BITS) + prod1_q;
  assign gain  = $signed({1'b0, volume_i});

  // round half up, then floor shift
  assign rnd = wto_pkg::RND_W'(prod2_q) + (wto_pkg::RND_W'(1) <<< (wto_pkg::SHIFT - 1));
  assign res = rnd[wto_pkg::RND_W-1:wto_pkg::SHIFT];

  always_comb begin
    priority if (res > wto_pkg::SAT_HI) begin
      sat = wto_pkg::SAT_HI[wto_pkg::SAMPLE_BITS-1:0];
    end else if (res < wto_pkg::SAT_LO) begin
      sat = wto_pkg::SAT_LO[wto_pkg::SAMPLE_BITS-1:0];
    end else begin
      sat = res[wto_pkg::SAMPLE_BITS-1:0];
    end
  end

  // carry out of the phase sum is the wrap
  assign sum = {1'b0, phase_q} + (wto_pkg::PHASE_W + 1)'(increment_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.ld_word) begin
      table_mem[addr_w] <= sample_value_i;
    end
    if (cmd_i.tick_rd) begin
      a_q <= table_mem[addr_a];
      b_q <= table_mem[addr_b];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.ld_map) begin
      map_mem[frequency_key_i] <= table_number_i;
    end
    if (cmd_i.note_on) begin
      map_q <= map_mem[frequency_key_i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul1) begin
      prod1_q <= wto_pkg::PROD1_W'(diff * frac);
    end
    if (cmd_i.mul2) begin
      prod2_q <= wto_pkg::PROD2_W'(s_sum * gain);
    end
    if (cmd_i.fin) begin
      sample_q  <= sat;
      wrapped_q <= sum[wto_pkg::PHASE_W];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= '0;
      increment_q <= '0;
      cur_table_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.note_on) begin
        phase_q     <= '0;
        increment_q <= phase_increment_i;
      end else if (cmd_i.fin) begin
        phase_q <= sum[wto_pkg::PHASE_W-1:0];
      end
      if (cmd_i.map_sel) begin
        cur_table_q <= map_q;
      end
      if (cmd_i.fin) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign status_o.out_free = !out_valid_q || out_ready_i;
  assign out_valid_o       = out_valid_q;
  assign sample_out_o      = sample_q;
  assign wrapped_o         = wrapped_q;

endmodule

// File: hw/rtl/wavetable_oscillator_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wavetable_oscillator_top
// Band-limited wavetable oscillator with linear interpolation and gain.
// ----------------------------------------------------------------------------
// Usage:
//   Input words (in_valid_i/in_ready_o) carry a mode. Load-word writes one
//   Q1.15 sample into the table store, load-map writes one entry of the
//   frequency map. Note-on loads the increment, clears the phase and selects
//   the table through the map: map read, then table select. A tick yields
//   one output word (out_valid_o/out_ready_i): sample_out_o and wrapped_o.
//   A tick steps through accept and table read of both neighbors, slope
//   multiply, gain multiply, then round/saturate and phase step; the input
//   is not ready for another word until that last step is done.
//   The output register lets the next word be accepted while a result waits;
//   a tick that finishes while the register is still full holds in its last
//   step until the receiver takes the old word.
//   Reset clears phase, increment, table select, gain and handshake state.
//   Table store and map hold no reset value: load them before use.
//   volume_gain (Q0.16) sits at APB address 0; write it only while idle.
// ----------------------------------------------------------------------------
module wavetable_oscillator_top (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // input words
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic [1:0]                           mode_i,
  input  logic [wto_pkg::TNUM_W-1:0]           table_number_i,
  input  logic [wto_pkg::POS_W-1:0]            table_offset_i,
  input  logic signed [wto_pkg::SAMPLE_BITS-1:0] sample_value_i,
  input  logic [wto_pkg::KEY_W-1:0]            frequency_key_i,
  input  logic [wto_pkg::INC_W-1:0]            phase_increment_i,
  // output words
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic signed [wto_pkg::SAMPLE_BITS-1:0] sample_out_o,
  output logic                                 wrapped_o,
  // APB configuration port
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [2:0]                           paddr,
  input  logic [31:0]                          pwdata,
  output logic [31:0]                          prdata,
  output logic                                 pready
);

  wto_pkg::cmd_t    cmd;
  wto_pkg::status_t status;

  logic [wto_pkg::VOL_W-1:0] volume_q;
  logic                      reg_sel;

  // register index is the word address; only index 0 exists
  assign reg_sel = ({paddr[2], 2'b00} == wto_pkg::REG_VOLUME);
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      volume_q <= '0;
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      volume_q <= pwdata[wto_pkg::VOL_W-1:0];
    end
  end

  assign prdata = reg_sel ? {{(32 - wto_pkg::VOL_W){1'b0}}, volume_q} : 32'd0;

  wto_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .mode_i     (mode_i),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  wto_datapath u_datapath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .status_o          (status),
    .table_number_i    (table_number_i),
    .table_offset_i    (table_offset_i),
    .sample_value_i    (sample_value_i),
    .frequency_key_i   (frequency_key_i),
    .phase_increment_i (phase_increment_i),
    .volume_i          (volume_q),
    .out_ready_i       (out_ready_i),
    .out_valid_o       (out_valid_o),
    .sample_out_o      (sample_out_o),
    .wrapped_o         (wrapped_o)
  );

  // a tick blocks the input side while it is worked on
  a_tick_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && (mode_i == wto_pkg::MODE_TICK)) |=> !in_ready_o)
    else $error("input accepted during tick");

  // with the output register empty, an accepted tick leads to a result word
  a_tick_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && (mode_i == wto_pkg::MODE_TICK) && !out_valid_o)
      |-> ##4 out_valid_o)
    else $error("tick result missing");

  // note-on and loads give no result word
  a_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && (mode_i != wto_pkg::MODE_TICK) && !out_valid_o)
      |=> !out_valid_o)
    else $error("result word from non-tick");

  // a load leaves the input ready for the next word
  a_load_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o &&
     ((mode_i == wto_pkg::MODE_LOAD_WORD) || (mode_i == wto_pkg::MODE_LOAD_MAP)))
      |=> in_ready_o)
    else $error("load did not return to idle");

endmodule

// File: tb/sv/wto_sample_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wto_sample_checker
// Watches the input, output and APB channels of the wavetable oscillator,
// keeps its own copy of tables, map, phase and gain, works out each tick's
// sample and compares it with the output words in order.
// ----------------------------------------------------------------------------
module wto_sample_checker
  import wto_pkg::*;
(
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  input  logic                          in_ready_i,
  input  logic [1:0]                    mode_i,
  input  logic [TNUM_W-1:0]             table_number_i,
  input  logic [POS_W-1:0]              table_offset_i,
  input  logic signed [SAMPLE_BITS-1:0] sample_value_i,
  input  logic [KEY_W-1:0]              frequency_key_i,
  input  logic [INC_W-1:0]              phase_increment_i,
  input  logic                          out_valid_i,
  input  logic                          out_ready_i,
  input  logic signed [SAMPLE_BITS-1:0] sample_out_i,
  input  logic                          wrapped_i,
  input  logic                          psel_i,
  input  logic                          penable_i,
  input  logic                          pwrite_i,
  input  logic [2:0]                    paddr_i,
  input  logic [31:0]                   pwdata_i,
  input  logic                          pready_i,
  output int                            mismatch_count_o,
  output int                            samples_pending_o
);

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          wrapped;
  } tick_word_t;

  logic signed [SAMPLE_BITS-1:0] wave_mem [TABLE_DEPTH];
  logic [TNUM_W-1:0]             key_map  [MAP_DEPTH];

  logic [PHASE_W-1:0] phase;
  logic [PHASE_W-1:0] step;
  logic [TNUM_W-1:0]  cur_table;
  longint             volume;
  tick_word_t         pending_samples [$];
  int                 mismatches;
  int                 reported;

  always @(posedge clk_i or negedge rst_ni) begin : monitor
    longint             a;
    longint             b;
    longint             frac;
    longint             acc;
    longint             rnd;
    logic [POS_W-1:0]   pos;
    logic [POS_W-1:0]   nxt;
    logic [PHASE_W:0]   sum;
    tick_word_t         w;
    tick_word_t         got;
    if (!rst_ni) begin
      phase      = '0;
      step       = '0;
      cur_table  = '0;
      volume     = 0;
      mismatches = 0;
      reported   = 0;
      pending_samples.delete();
    end else begin
      if (psel_i && penable_i && pwrite_i && pready_i && paddr_i == REG_VOLUME) begin
        volume = longint'(pwdata_i[VOL_W-1:0]);
      end
      if (in_valid_i && in_ready_i) begin
        case (mode_e'(mode_i))
          MODE_NOTE_ON: begin
            step      = PHASE_W'(phase_increment_i);
            phase     = '0;
            cur_table = key_map[frequency_key_i];
          end
          MODE_LOAD_WORD: wave_mem[{table_number_i, table_offset_i}] = sample_value_i;
          MODE_LOAD_MAP:  key_map[frequency_key_i] = table_number_i;
          MODE_TICK: begin
            pos  = phase[PHASE_W-1:FRAC_BITS];
            nxt  = pos + POS_W'(1);
            frac = longint'(phase[FRAC_BITS-1:0]);
            a    = longint'(wave_mem[{cur_table, pos}]);
            b    = longint'(wave_mem[{cur_table, nxt}]);
            acc  = a * ((longint'(1) <<< FRAC_BITS) - frac) + b * frac;
            // floor shift of the biased product rounds half up
            rnd  = (acc * volume + (longint'(1) <<< (SHIFT - 1))) >>> SHIFT;
            if (rnd > (longint'(1) <<< (SAMPLE_BITS - 1)) - 1)
              rnd = (longint'(1) <<< (SAMPLE_BITS - 1)) - 1;
            if (rnd < -(longint'(1) <<< (SAMPLE_BITS - 1)))
              rnd = -(longint'(1) <<< (SAMPLE_BITS - 1));
            sum       = {1'b0, phase} + {1'b0, step};
            w.sample  = rnd[SAMPLE_BITS-1:0];
            w.wrapped = sum[PHASE_W];
            phase     = sum[PHASE_W-1:0];
            pending_samples.push_back(w);
          end
          default: ;
        endcase
      end
      if (out_valid_i && out_ready_i) begin
        got.sample  = sample_out_i;
        got.wrapped = wrapped_i;
        if (pending_samples.size() == 0) begin
          mismatches++;
          if (reported < 10) begin
            reported++;
            $display("%0t: unexpected word sample %0d wrapped %0b",
                     $time, got.sample, got.wrapped);
          end
        end else begin
          w = pending_samples.pop_front();
          if (got.sample !== w.sample || got.wrapped !== w.wrapped) begin
            mismatches++;
            if (reported < 10) begin
              reported++;
              $display("%0t: mismatch sample exp %0d got %0d, wrapped exp %0b got %0b",
                       $time, w.sample, got.sample, w.wrapped, got.wrapped);
            end
          end
        end
      end
    end
    mismatch_count_o  <= mismatches;
    samples_pending_o <= pending_samples.size();
  end

endmodule

// File: tb/sv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives the wavetable oscillator with table and map loads, note-ons and
// ticks under random backpressure, sweeps the volume gain over APB, and
// gives the verdict from the checker's mismatch count.
// ----------------------------------------------------------------------------
module tb_top;
  import wto_pkg::*;

  // clock, reset
  logic clk;
  logic rst_n = 1'b0;

  // input channel
  logic                          in_valid = 1'b0;
  logic                          in_ready;
  logic [1:0]                    mode = MODE_TICK;
  logic [TNUM_W-1:0]             table_number = '0;
  logic [POS_W-1:0]              table_offset = '0;
  logic signed [SAMPLE_BITS-1:0] sample_value = '0;
  logic [KEY_W-1:0]              frequency_key = '0;
  logic [INC_W-1:0]              phase_increment = '0;

  // output channel
  logic                          out_valid;
  logic                          out_ready = 1'b0;
  logic signed [SAMPLE_BITS-1:0] sample_out;
  logic                          wrapped;

  // APB
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  int mismatch_count;
  int samples_pending;

  // Stimulus-side bookkeeping: which table and map entries hold data, and
  // where the phase will be, so that a tick never reads an unloaded entry.
  bit                 tbl_loaded [TABLE_DEPTH];
  bit                 map_loaded [MAP_DEPTH];
  logic [TNUM_W-1:0]  map_table  [MAP_DEPTH];
  logic [PHASE_W-1:0] ph_shadow  = '0;
  logic [PHASE_W-1:0] inc_shadow = '0;
  logic [TNUM_W-1:0]  tbl_shadow = '0;

  int items_sent = 0;
  bit tx_idle_on = 1'b0;   // sender gaps allowed
  bit rx_idle_on = 1'b0;   // receiver stalls allowed
  bit long_hold  = 1'b0;   // request one long receiver hold-off

  localparam int LONG_HOLD_CYCLES = 300;
  localparam int DRAIN_CYCLES     = 8;   // covers a tick or note-on still in flight

  wavetable_oscillator_top DUT (
    .clk_i             (clk),
    .rst_ni            (rst_n),
    .in_valid_i        (in_valid),
    .in_ready_o        (in_ready),
    .mode_i            (mode),
    .table_number_i    (table_number),
    .table_offset_i    (table_offset),
    .sample_value_i    (sample_value),
    .frequency_key_i   (frequency_key),
    .phase_increment_i (phase_increment),
    .out_valid_o       (out_valid),
    .out_ready_i       (out_ready),
    .sample_out_o      (sample_out),
    .wrapped_o         (wrapped),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready)
  );

  wto_sample_checker u_checker (
    .clk_i             (clk),
    .rst_ni            (rst_n),
    .in_valid_i        (in_valid),
    .in_ready_i        (in_ready),
    .mode_i            (mode),
    .table_number_i    (table_number),
    .table_offset_i    (table_offset),
    .sample_value_i    (sample_value),
    .frequency_key_i   (frequency_key),
    .phase_increment_i (phase_increment),
    .out_valid_i       (out_valid),
    .out_ready_i       (out_ready),
    .sample_out_i      (sample_out),
    .wrapped_i         (wrapped),
    .psel_i            (psel),
    .penable_i         (penable),
    .pwrite_i          (pwrite),
    .paddr_i           (paddr),
    .pwdata_i          (pwdata),
    .pready_i          (pready),
    .mismatch_count_o  (mismatch_count),
    .samples_pending_o (samples_pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop in case a word never shows up.
  initial begin : watchdog
    #(64'd5_000_000);
    $display("CHECK FAILED");
    $finish;
  end

  // Receiver: random stall bursts, one long hold-off on request.
  initial begin : rx_ready
    forever begin
      @(posedge clk);
      if (long_hold) begin
        out_ready <= 1'b0;
        repeat (LONG_HOLD_CYCLES) @(posedge clk);
        long_hold = 1'b0;
        out_ready <= 1'b1;
      end else if (rx_idle_on && $urandom_range(0, 9) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 19)) @(posedge clk);
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // random field pickers, biased toward the extremes
  // ---------------------------------------------------------------------------
  function automatic logic signed [SAMPLE_BITS-1:0] pick_sample();
    case ($urandom_range(0, 7))
      0:       return 16'sh7FFF;
      1:       return 16'sh8000;
      2:       return 16'sh0000;
      3:       return 16'shFFFF;
      default: return $signed(SAMPLE_BITS'($urandom));
    endcase
  endfunction

  function automatic logic [TNUM_W-1:0] pick_table();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return TNUM_W'(TABLE_COUNT - 1);
      2, 3:    return TNUM_W'($urandom);
      default: return TNUM_W'($urandom_range(1, 3));  // few tables, lots of reuse
    endcase
  endfunction

  function automatic logic [KEY_W-1:0] pick_key();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return KEY_W'(MAP_DEPTH - 1);
      2:       return KEY_W'($urandom);
      default: return KEY_W'($urandom_range(870, 890));
    endcase
  endfunction

  function automatic logic [INC_W-1:0] pick_inc();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return {INC_W{1'b1}};
      2:       return INC_W'($urandom_range(0, 1 << FRAC_BITS));
      3:       return INC_W'($urandom_range(0, 1 << 26));
      default: return INC_W'($urandom);
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // input channel driver
  // ---------------------------------------------------------------------------
  // Offers one word and waits for it to be taken. Valid stays high across
  // back-to-back words; it drops only for a gap or in wait_drained.
  task automatic send_word(mode_e m, logic [TNUM_W-1:0] tn, logic [POS_W-1:0] off,
                           logic signed [SAMPLE_BITS-1:0] sv, logic [KEY_W-1:0] key,
                           logic [INC_W-1:0] inc);
    if (tx_idle_on && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    in_valid        <= 1'b1;
    mode            <= m;
    table_number    <= tn;
    table_offset    <= off;
    sample_value    <= sv;
    frequency_key   <= key;
    phase_increment <= inc;
    do @(posedge clk); while (!in_ready);
    items_sent++;
  endtask

  task automatic load_word(logic [TNUM_W-1:0] tn, logic [POS_W-1:0] off,
                           logic signed [SAMPLE_BITS-1:0] sv);
    send_word(MODE_LOAD_WORD, tn, off, sv, KEY_W'($urandom), INC_W'($urandom));
    tbl_loaded[{tn, off}] = 1'b1;
  endtask

  task automatic load_map(logic [KEY_W-1:0] key, logic [TNUM_W-1:0] tn);
    send_word(MODE_LOAD_MAP, tn, POS_W'($urandom), $signed(SAMPLE_BITS'($urandom)),
              key, INC_W'($urandom));
    map_loaded[key] = 1'b1;
    map_table[key]  = tn;
  endtask

  // note-on through an unloaded key gets its map entry written first
  task automatic note_on(logic [KEY_W-1:0] key, logic [INC_W-1:0] inc);
    if (!map_loaded[key]) load_map(key, pick_table());
    send_word(MODE_NOTE_ON, TNUM_W'($urandom), POS_W'($urandom),
              $signed(SAMPLE_BITS'($urandom)), key, inc);
    tbl_shadow = map_table[key];
    ph_shadow  = '0;
    inc_shadow = PHASE_W'(inc);
  endtask

  // a tick is preceded by loads of whichever neighbor is still empty
  task automatic tick();
    logic [POS_W-1:0] pos;
    logic [POS_W-1:0] nxt;
    pos = ph_shadow[PHASE_W-1:FRAC_BITS];
    nxt = pos + POS_W'(1);
    if (!tbl_loaded[{tbl_shadow, pos}]) load_word(tbl_shadow, pos, pick_sample());
    if (!tbl_loaded[{tbl_shadow, nxt}]) load_word(tbl_shadow, nxt, pick_sample());
    send_word(MODE_TICK, TNUM_W'($urandom), POS_W'($urandom),
              $signed(SAMPLE_BITS'($urandom)), KEY_W'($urandom), INC_W'($urandom));
    ph_shadow = ph_shadow + inc_shadow;
  endtask

  // drop valid, wait for the last word out, then let any note-on settle
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (samples_pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // APB write of the gain: setup cycle, then access until pready
  task automatic set_volume(logic [VOL_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= REG_VOLUME;
    pwdata  <= 32'(value);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // mostly note-on/tick runs with random content, plus stray loads
  task automatic random_items(int count);
    int stop;
    int pick;
    stop = items_sent + count;
    while (items_sent < stop) begin
      pick = $urandom_range(0, 99);
      if (pick < 55)      tick();
      else if (pick < 65) note_on(pick_key(), pick_inc());
      else if (pick < 85) load_word(pick_table(), POS_W'($urandom), pick_sample());
      else if (pick < 93) load_map(pick_key(), pick_table());
      else                repeat ($urandom_range(2, 12)) tick();
    end
  endtask

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    logic [VOL_W-1:0] gains [5];
    gains = '{16'h0000, 16'h8000, 16'h0000, 16'h0001, 16'hFFFF};
    gains[2] = VOL_W'($urandom);

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: full gain, extreme samples, extreme keys and increments.
    set_volume(16'hFFFF);
    load_word('0, '0, 16'sh7FFF);
    load_word('0, POS_W'(1), 16'sh8000);
    tick();                                  // straight after reset: table 0, phase 0
    load_map(KEY_W'(MAP_DEPTH - 1), '0);
    load_map('0, TNUM_W'(TABLE_COUNT - 1));
    note_on(KEY_W'(MAP_DEPTH - 1), {INC_W{1'b1}});
    repeat (3) tick();                       // largest step, wraps on the third
    note_on('0, INC_W'(1));                  // smallest fraction, top table
    repeat (2) tick();
    note_on('0, 31'h7FF8_0000);
    repeat (3) tick();                       // last entry interpolates with the first
    note_on(15'd880, '0);                    // zero step holds the phase
    repeat (2) tick();
    load_word(TNUM_W'(TABLE_COUNT - 1), '1, 16'sh0000);
    note_on(pick_key(), pick_inc());
    tick();
    wait_drained();

    // Random phases over several gain settings.
    for (int ph = 0; ph < 5; ph++) begin
      set_volume(gains[ph]);
      tx_idle_on = (ph < 4) && ($urandom_range(0, 3) != 0);
      rx_idle_on = (ph < 4) && ($urandom_range(0, 3) != 0);
      if (ph == 1) begin
        // receiver holds off while the sender keeps offering ticks
        long_hold = 1'b1;
        repeat (40) tick();
      end
      if (ph == 2) begin
        random_items(80);
        wait_drained();                      // sender pauses until all words are out
        random_items(80);
      end else begin
        random_items(160);
      end
      wait_drained();
    end

    // wait_drained already ran; give strays time to show before the verdict
    repeat (20) @(posedge clk);
    if (mismatch_count == 0 && samples_pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
